// File: hdl/shpc_pkg.sv
// Shared types and constants for the half-step stepper position controller.
`timescale 1ns / 1ps
`default_nettype none

package shpc_pkg;

    // Fixed field widths of the item and register words.
    localparam int ACTION_BITS   = 4;
    localparam int VALUE_BITS    = 24;
    localparam int PERIOD_BITS   = 24;
    localparam int PHASE_BITS    = 3;
    localparam int COIL_BITS     = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int PADDR_BITS    = 4;
    localparam int REG_IDX_BITS  = 2;

    // Default for the internal position range.
    localparam int POSITION_BITS_DEFAULT = 24;

    // Register reset values.
    localparam logic [APB_DATA_BITS-1:0] PHASE_CODE_RESET  = 32'hB9D5_76EA;
    localparam logic [PERIOD_BITS-1:0]   HALF_PERIOD_RESET = 24'd160000;
    localparam logic [VALUE_BITS-1:0]    HOME_RESET        = '0;

    // Coil pattern shown while the coils are released.
    localparam logic [COIL_BITS-1:0] COILS_OFF = 4'hF;

    // Register indexes (byte address / 4).
    localparam logic [REG_IDX_BITS-1:0] REG_PHASE_CODE  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_HALF_PERIOD = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_HOME        = 2'd2;

    // Action codes.
    localparam logic [ACTION_BITS-1:0] ACT_TICK    = 4'd0;
    localparam logic [ACTION_BITS-1:0] ACT_GOTO    = 4'd1;
    localparam logic [ACTION_BITS-1:0] ACT_RUN     = 4'd2;
    localparam logic [ACTION_BITS-1:0] ACT_FINISH  = 4'd3;
    localparam logic [ACTION_BITS-1:0] ACT_HOME    = 4'd4;
    localparam logic [ACTION_BITS-1:0] ACT_HOLD    = 4'd5;
    localparam logic [ACTION_BITS-1:0] ACT_RELEASE = 4'd6;
    localparam logic [ACTION_BITS-1:0] ACT_TELL    = 4'd7;
    localparam logic [ACTION_BITS-1:0] ACT_ZERO    = 4'd8;

    // Configuration seen by the stepping logic.
    typedef struct packed {
        logic [APB_DATA_BITS-1:0]     phase_code;
        logic [PERIOD_BITS-1:0]       half_period;
        logic signed [VALUE_BITS-1:0] home_position;
    } cfg_t;

endpackage

`default_nettype wire

// File: hdl/shpc_if.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface shpc_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        action;
    logic signed [23:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface shpc_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         coil_phases;
    logic signed [23:0] position;
    logic               running;
    logic               released;
    logic               report_valid;
    logic               arrived;

    modport source (output valid, output coil_phases, output position, output running,
                    output released, output report_valid, output arrived, input ready);
    modport sink   (input valid, input coil_phases, input position, input running,
                    input released, input report_valid, input arrived, output ready);
endinterface

`default_nettype wire

// File: hdl/shpc_cfg_regs.sv
// APB configuration registers of the stepper position controller.
`timescale 1ns / 1ps
`default_nettype none

module shpc_cfg_regs
    import shpc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_BITS-1:0]    paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t                    cfg_reg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_code    <= PHASE_CODE_RESET;
            cfg_reg.half_period   <= HALF_PERIOD_RESET;
            cfg_reg.home_position <= HOME_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PHASE_CODE:  cfg_reg.phase_code    <= pwdata;
                REG_HALF_PERIOD: cfg_reg.half_period   <= pwdata[PERIOD_BITS-1:0];
                REG_HOME:        cfg_reg.home_position <= pwdata[VALUE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Read-back mux; the unused address reads as zero.
    always_comb
    begin
        case (reg_idx)
            REG_PHASE_CODE:  prdata = cfg_reg.phase_code;
            REG_HALF_PERIOD: prdata = {{(APB_DATA_BITS-PERIOD_BITS){1'b0}},
                                       cfg_reg.half_period};
            REG_HOME:        prdata = {{(APB_DATA_BITS-VALUE_BITS)
                                        {cfg_reg.home_position[VALUE_BITS-1]}},
                                       cfg_reg.home_position};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/stepper_half_step_position_controller.sv
// Top level: half-step stepper position controller with one result per command.
//
//  Channel | Direction | Handshake      | Word
//  cmd     | in        | valid / ready  | action, value
//  rsp     | out       | valid / ready  | coil_phases, position, running, released,
//          |           |                | report_valid, arrived
//  apb     | in        | psel / penable | phase_code, half_period, home_position
//
// Each command word is processed combinationally: the next state and the result are
// computed from the state registers and land in the result register at the same edge.
// A new word is taken every cycle while the result register is empty or being drained,
// so one word per cycle is sustained; a stalled rsp holds cmd ready low.
// Reset (rst_n, asynchronous) restores the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stepper_half_step_position_controller
    import shpc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_BITS-1:0]    paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready,
    shpc_in_if.sink                       cmd,
    shpc_out_if.source                    rsp
);

    // Comparison width covers both the position range and the 24-bit fields.
    localparam int PB = POSITION_BITS;
    localparam int CW = ((PB > VALUE_BITS) ? PB : VALUE_BITS) + 1;
    localparam logic signed [CW-1:0] POS_MAX_W = {{(CW-PB+1){1'b0}}, {(PB-1){1'b1}}};
    localparam logic signed [CW-1:0] POS_MIN_W = ~POS_MAX_W;
    localparam logic signed [CW-1:0] ONE_W     = {{(CW-1){1'b0}}, 1'b1};

    cfg_t cfg;

    // Stepping state.
    logic signed [PB-1:0]  step_reg, step_next;
    logic signed [PB-1:0]  goal_reg, goal_next;
    logic                  dir_fwd_reg, dir_fwd_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  half_reg, half_next;
    logic                  released_reg, released_next;
    logic                  hold_reg, hold_next;
    logic                  pending_reg, pending_next;
    logic                  motion_reg, motion_next;
    logic [PERIOD_BITS-1:0] tick_reg, tick_next;

    // Result register.
    logic                  out_valid_reg;
    logic [COIL_BITS-1:0]  coil_reg;
    logic [VALUE_BITS-1:0] position_reg;
    logic                  running_reg;
    logic                  out_released_reg;
    logic                  report_reg;
    logic                  arrived_reg;

    logic                  accept;
    logic                  report_c;
    logic                  arrived_c;
    logic                  start_c;
    logic [PERIOD_BITS-1:0] tick_inc;
    logic signed [CW-1:0]  step_ext;
    logic signed [CW-1:0]  step_next_ext;
    logic signed [CW-1:0]  value_ext;
    logic signed [CW-1:0]  home_ext;
    logic [COIL_BITS-1:0]  coil_c;

    // Saturate a wide signed value to the position range.
    function automatic logic signed [PB-1:0] clamp_pos(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            if (v > POS_MAX_W)
                r = POS_MAX_W;
            else if (v < POS_MIN_W)
                r = POS_MIN_W;
            else
                r = v;
            return r[PB-1:0];
        end
    endfunction

    shpc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: take a word whenever the result register is free or draining.
    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign step_ext  = {{(CW-PB){step_reg[PB-1]}}, step_reg};
    assign value_ext = {{(CW-VALUE_BITS){cmd.value[VALUE_BITS-1]}}, cmd.value};
    assign home_ext  = {{(CW-VALUE_BITS){cfg.home_position[VALUE_BITS-1]}}, cfg.home_position};
    assign tick_inc  = tick_reg + 1'b1;

    // Next state for the accepted command word.
    always_comb
    begin
        step_next     = step_reg;
        goal_next     = goal_reg;
        dir_fwd_next  = dir_fwd_reg;
        phase_next    = phase_reg;
        half_next     = half_reg;
        released_next = released_reg;
        hold_next     = hold_reg;
        pending_next  = pending_reg;
        motion_next   = motion_reg;
        tick_next     = tick_reg;
        report_c      = 1'b0;
        arrived_c     = 1'b0;
        start_c       = 1'b0;

        case (cmd.action)
            ACT_TICK:
            begin
                if (motion_reg)
                begin
                    if (tick_inc >= cfg.half_period)
                    begin
                        tick_next = '0;
                        if (step_reg == goal_reg)
                        begin
                            // Arrived: stop and flush a pending report.
                            motion_next = 1'b0;
                            half_next   = 1'b0;
                            arrived_c   = 1'b1;
                            if (pending_reg)
                            begin
                                report_c     = 1'b1;
                                pending_next = 1'b0;
                            end
                            if (!hold_reg)
                                released_next = 1'b1;
                        end
                        else
                        begin
                            // One half step; position moves on every second one.
                            phase_next = dir_fwd_reg ? phase_reg - 1'b1 : phase_reg + 1'b1;
                            half_next  = !half_reg;
                            if (half_reg)
                                step_next = dir_fwd_reg ? step_reg + 1'b1 : step_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            ACT_GOTO:
            begin
                goal_next = clamp_pos(value_ext);
                start_c   = 1'b1;
            end
            ACT_RUN:
            begin
                dir_fwd_next = (cmd.value > 0);
                goal_next    = (cmd.value > 0) ? POS_MAX_W[PB-1:0] : POS_MIN_W[PB-1:0];
                start_c      = 1'b1;
            end
            ACT_FINISH:
            begin
                pending_next = 1'b1;
                goal_next    = clamp_pos(dir_fwd_reg ? step_ext + ONE_W : step_ext - ONE_W);
            end
            ACT_HOME:
            begin
                goal_next = clamp_pos(home_ext);
                start_c   = 1'b1;
            end
            ACT_HOLD:
            begin
                hold_next     = (cmd.value != '0);
                released_next = (cmd.value == '0);
            end
            ACT_RELEASE:
            begin
                released_next = 1'b1;
            end
            ACT_TELL:
            begin
                report_c = 1'b1;
            end
            ACT_ZERO:
            begin
                motion_next  = 1'b0;
                tick_next    = '0;
                half_next    = 1'b0;
                pending_next = 1'b0;
                step_next    = clamp_pos(home_ext);
                goal_next    = clamp_pos(home_ext);
                if (!hold_reg)
                    released_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Start motion when the goal differs from the position.
        if (start_c && (step_next != goal_next))
        begin
            dir_fwd_next  = (goal_next > step_next);
            half_next     = 1'b0;
            released_next = 1'b0;
            motion_next   = 1'b1;
        end
    end

    assign step_next_ext = {{(CW-PB){step_next[PB-1]}}, step_next};
    assign coil_c = released_next ? COILS_OFF
                                  : cfg.phase_code[{phase_next, 2'b00} +: COIL_BITS];

    // State update on accepted words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            goal_reg     <= '0;
            dir_fwd_reg  <= 1'b0;
            phase_reg    <= '0;
            half_reg     <= 1'b0;
            released_reg <= 1'b1;
            hold_reg     <= 1'b1;
            pending_reg  <= 1'b0;
            motion_reg   <= 1'b0;
            tick_reg     <= '0;
        end
        else if (accept)
        begin
            step_reg     <= step_next;
            goal_reg     <= goal_next;
            dir_fwd_reg  <= dir_fwd_next;
            phase_reg    <= phase_next;
            half_reg     <= half_next;
            released_reg <= released_next;
            hold_reg     <= hold_next;
            pending_reg  <= pending_next;
            motion_reg   <= motion_next;
            tick_reg     <= tick_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coil_reg         <= coil_c;
            position_reg     <= step_next_ext[VALUE_BITS-1:0];
            running_reg      <= motion_next;
            out_released_reg <= released_next;
            report_reg       <= report_c;
            arrived_reg      <= arrived_c;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.coil_phases  = coil_reg;
    assign rsp.position     = position_reg;
    assign rsp.running      = running_reg;
    assign rsp.released     = out_released_reg;
    assign rsp.report_valid = report_reg;
    assign rsp.arrived      = arrived_reg;

endmodule

`default_nettype wire

// File: sim/shpc_motion_checker.sv
// Result checker for the half-step stepper controller: predicts every result word and compares.
`timescale 1ns / 1ps

module shpc_motion_checker
    import shpc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_BITS-1:0]    paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    input  wire logic [APB_DATA_BITS-1:0] prdata,
    input  wire logic                     pready,
    shpc_in_if                            cmd,
    shpc_out_if                           rsp,
    output int                            mismatches,
    output int                            words_waiting,
    output int                            words_checked,
    output int                            stops_seen,
    output int                            reports_seen
);

    // Limits of the position range; goals saturate to these.
    localparam longint POS_HI = (longint'(1) <<< (POSITION_BITS_DEFAULT - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;

    typedef struct packed {
        logic [COIL_BITS-1:0]         coils;
        logic signed [VALUE_BITS-1:0] position;
        logic                         running;
        logic                         released;
        logic                         report;
        logic                         arrived;
    } motor_word_t;

    // Register copy and motor state as the block should hold them.
    cfg_t                         regs;
    logic signed [VALUE_BITS-1:0] pos;
    logic signed [VALUE_BITS-1:0] goal;
    logic                         fwd;
    logic [PHASE_BITS-1:0]        phase;
    logic                         half_done;
    logic                         coils_off;
    logic                         hold_on;
    logic                         report_due;
    logic                         moving;
    logic [PERIOD_BITS-1:0]       ticks;

    motor_word_t predicted_words[$];

    function automatic logic signed [VALUE_BITS-1:0] saturate(input longint v);
        if (v > POS_HI)
        begin
            return VALUE_BITS'(POS_HI);
        end
        if (v < POS_LO)
        begin
            return VALUE_BITS'(POS_LO);
        end
        return v[VALUE_BITS-1:0];
    endfunction

    function automatic void reset_motor();
        regs.phase_code    = PHASE_CODE_RESET;
        regs.half_period   = HALF_PERIOD_RESET;
        regs.home_position = HOME_RESET;
        pos        = '0;
        goal       = '0;
        fwd        = 1'b0;
        phase      = '0;
        half_done  = 1'b0;
        coils_off  = 1'b1;
        hold_on    = 1'b1;
        report_due = 1'b0;
        moving     = 1'b0;
        ticks      = '0;
    endfunction

    // A start does nothing when already at the goal; the tick divider keeps its count.
    function automatic void begin_motion();
        if (pos == goal)
        begin
            return;
        end
        fwd       = (goal > pos);
        half_done = 1'b0;
        coils_off = 1'b0;
        moving    = 1'b1;
    endfunction

    function automatic void halt_motion();
        moving    = 1'b0;
        ticks     = '0;
        half_done = 1'b0;
    endfunction

    // Forward walks the phase index down; the position moves on every second half step.
    function automatic void take_half_step();
        if (fwd)
        begin
            phase = phase - 1'b1;
        end
        else
        begin
            phase = phase + 1'b1;
        end
        half_done = !half_done;
        if (!half_done)
        begin
            pos = fwd ? pos + 1'b1 : pos - 1'b1;
        end
    endfunction

    function automatic motor_word_t advance_motor(input logic [ACTION_BITS-1:0] act,
                                                  input logic signed [VALUE_BITS-1:0] val);
        motor_word_t w;
        w.report  = 1'b0;
        w.arrived = 1'b0;
        case (act)
            ACT_TICK:
            begin
                if (moving)
                begin
                    ticks = ticks + 1'b1;
                    if (ticks >= regs.half_period)
                    begin
                        ticks = '0;
                        if (pos == goal)
                        begin
                            halt_motion();
                            w.arrived = 1'b1;
                            if (report_due)
                            begin
                                w.report   = 1'b1;
                                report_due = 1'b0;
                            end
                            if (!hold_on)
                            begin
                                coils_off = 1'b1;
                            end
                        end
                        else
                        begin
                            take_half_step();
                        end
                    end
                end
            end
            ACT_GOTO:
            begin
                goal = saturate(longint'(val));
                begin_motion();
            end
            ACT_RUN:
            begin
                fwd  = (val > 0);
                goal = fwd ? saturate(POS_HI) : saturate(POS_LO);
                begin_motion();
            end
            ACT_FINISH:
            begin
                report_due = 1'b1;
                goal = saturate(longint'(pos) + (fwd ? 1 : -1));
            end
            ACT_HOME:
            begin
                goal = saturate(longint'($signed(regs.home_position)));
                begin_motion();
            end
            ACT_HOLD:
            begin
                hold_on   = (val != 0);
                coils_off = !hold_on;
            end
            ACT_RELEASE:
            begin
                coils_off = 1'b1;
            end
            ACT_TELL:
            begin
                w.report = 1'b1;
            end
            ACT_ZERO:
            begin
                halt_motion();
                report_due = 1'b0;
                pos  = saturate(longint'($signed(regs.home_position)));
                goal = pos;
                if (!hold_on)
                begin
                    coils_off = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        w.coils    = coils_off ? COILS_OFF : regs.phase_code[phase*COIL_BITS +: COIL_BITS];
        w.position = pos;
        w.running  = moving;
        w.released = coils_off;
        return w;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("checker: %0t: %s", $realtime, what);
    endtask

    task automatic check_word(input motor_word_t want);
        if (rsp.coil_phases !== want.coils)
        begin
            report_mismatch($sformatf("coil_phases %h, expected %h", rsp.coil_phases, want.coils));
        end
        if (rsp.position !== want.position)
        begin
            report_mismatch($sformatf("position %0d, expected %0d", rsp.position, want.position));
        end
        if (rsp.running !== want.running)
        begin
            report_mismatch($sformatf("running %b, expected %b", rsp.running, want.running));
        end
        if (rsp.released !== want.released)
        begin
            report_mismatch($sformatf("released %b, expected %b", rsp.released, want.released));
        end
        if (rsp.report_valid !== want.report)
        begin
            report_mismatch($sformatf("report_valid %b, expected %b", rsp.report_valid,
                                      want.report));
        end
        if (rsp.arrived !== want.arrived)
        begin
            report_mismatch($sformatf("arrived %b, expected %b", rsp.arrived, want.arrived));
        end
    endtask

    // Read data is compared over the width of the register only.
    task automatic check_readback(input logic [REG_IDX_BITS-1:0] idx);
        case (idx)
            REG_PHASE_CODE:
            begin
                if (prdata !== regs.phase_code)
                begin
                    report_mismatch($sformatf("phase_code reads %h, expected %h", prdata,
                                              regs.phase_code));
                end
            end
            REG_HALF_PERIOD:
            begin
                if (prdata[PERIOD_BITS-1:0] !== regs.half_period)
                begin
                    report_mismatch($sformatf("half_period reads %0d, expected %0d",
                                              prdata[PERIOD_BITS-1:0], regs.half_period));
                end
            end
            REG_HOME:
            begin
                if (prdata[VALUE_BITS-1:0] !== regs.home_position)
                begin
                    report_mismatch($sformatf("home_position reads %h, expected %h",
                                              prdata[VALUE_BITS-1:0], regs.home_position));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        mismatches    = 0;
        words_waiting = 0;
        words_checked = 0;
        stops_seen    = 0;
        reports_seen  = 0;
        reset_motor();
    end

    // Result words are matched before new command words are queued, since a result
    // can never belong to a word taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        motor_word_t next_word;
        if (!rst_n)
        begin
            reset_motor();
            predicted_words.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                words_checked++;
                if (predicted_words.size() == 0)
                begin
                    report_mismatch("result word with no command word waiting");
                end
                else
                begin
                    check_word(predicted_words.pop_front());
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                next_word = advance_motor(cmd.action, cmd.value);
                if (next_word.arrived)
                begin
                    stops_seen++;
                end
                if (next_word.report)
                begin
                    reports_seen++;
                end
                predicted_words.push_back(next_word);
            end
            if (psel && penable && pready)
            begin
                if (!pwrite)
                begin
                    check_readback(paddr[PADDR_BITS-1:2]);
                end
                else
                begin
                    case (paddr[PADDR_BITS-1:2])
                        REG_PHASE_CODE:  regs.phase_code    = pwdata;
                        REG_HALF_PERIOD: regs.half_period   = pwdata[PERIOD_BITS-1:0];
                        REG_HOME:        regs.home_position = pwdata[VALUE_BITS-1:0];
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        words_waiting = predicted_words.size();
    end

endmodule

// File: sim/tb.sv
// Testbench top: drives command words and register writes into the stepper controller.
`timescale 1ns / 1ps

module tb;
    import shpc_pkg::*;

    localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;
    localparam int     WORDS_PER_SETTING = 210;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_BITS-1:0]    paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int mismatches;
    int words_waiting;
    int words_checked;
    int stops_seen;
    int reports_seen;

    int                           send_idle_pct;
    int                           recv_idle_pct;
    int                           words_sent;
    int                           settings_used;
    logic signed [VALUE_BITS-1:0] home_now;

    shpc_in_if  cmd();
    shpc_out_if rsp();

    stepper_half_step_position_controller u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd),
        .rsp     (rsp)
    );

    shpc_motion_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cmd           (cmd),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .words_waiting (words_waiting),
        .words_checked (words_checked),
        .stops_seen    (stops_seen),
        .reports_seen  (reports_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side stalls at random at the current rate.
    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // One register access: setup phase, then access phase until pready.
    task automatic apb_access(input logic write, input logic [REG_IDX_BITS-1:0] idx,
                              input logic [APB_DATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_registers();
        apb_access(1'b0, REG_PHASE_CODE, '0);
        apb_access(1'b0, REG_HALF_PERIOD, '0);
        apb_access(1'b0, REG_HOME, '0);
    endtask

    task automatic set_registers(input logic [APB_DATA_BITS-1:0] code,
                                 input logic [PERIOD_BITS-1:0] period,
                                 input logic signed [VALUE_BITS-1:0] home);
        apb_access(1'b1, REG_PHASE_CODE, code);
        apb_access(1'b1, REG_HALF_PERIOD, APB_DATA_BITS'(period));
        apb_access(1'b1, REG_HOME, APB_DATA_BITS'(home));
        read_registers();
        home_now = home;
        settings_used++;
    endtask

    // Holds one command word until it is taken, with random gaps in front of it.
    task automatic send_word(input logic [ACTION_BITS-1:0] act,
                             input logic signed [VALUE_BITS-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid  <= 1'b1;
        cmd.action <= act;
        cmd.value  <= val;
        do @(posedge clk); while (!cmd.ready);
        words_sent++;
    endtask

    // Lets every outstanding result word drain, with a bound.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (words_waiting != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] near_home(input int offset);
        longint v;
        v = longint'(home_now) + offset;
        if (v > VALUE_MAX)
        begin
            v = VALUE_MAX;
        end
        if (v < VALUE_MIN)
        begin
            v = VALUE_MIN;
        end
        return v[VALUE_BITS-1:0];
    endfunction

    // Mostly ticks with goals close to home, so moves finish and stops happen often.
    task automatic send_random_word();
        int                           roll;
        logic [ACTION_BITS-1:0]       act;
        logic signed [VALUE_BITS-1:0] val;
        roll = $urandom_range(99);
        val  = near_home(int'($urandom_range(40)) - 20);
        if (roll < 58)
        begin
            act = ACT_TICK;
            val = VALUE_BITS'($urandom());
        end
        else if (roll < 70)
        begin
            act = ACT_GOTO;
            if ($urandom_range(7) == 0)
            begin
                val = VALUE_BITS'($urandom());
            end
        end
        else if (roll < 74)
        begin
            act = ACT_FINISH;
        end
        else if (roll < 77)
        begin
            act = ACT_HOME;
        end
        else if (roll < 80)
        begin
            act = ACT_HOLD;
            val = VALUE_BITS'($urandom());
            if ($urandom_range(1) == 0)
            begin
                val = '0;
            end
        end
        else if (roll < 83)
        begin
            act = ACT_RELEASE;
        end
        else if (roll < 87)
        begin
            act = ACT_TELL;
        end
        else if (roll < 90)
        begin
            act = ACT_ZERO;
        end
        else if (roll < 94)
        begin
            act = ACT_RUN;
            val = VALUE_BITS'(int'($urandom_range(2)) - 1);
            if ($urandom_range(3) == 0)
            begin
                val = VALUE_BITS'($urandom());
            end
        end
        else
        begin
            act = ACTION_BITS'($urandom_range((1 << ACTION_BITS) - 1, ACT_ZERO + 1));
            val = VALUE_BITS'($urandom());
        end
        send_word(act, val);
    endtask

    initial
    begin
        logic [APB_DATA_BITS-1:0]     codes [6];
        logic [PERIOD_BITS-1:0]       periods [6];
        logic signed [VALUE_BITS-1:0] homes [6];
        int                           ph;
        int                           n;
        int                           failures;

        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cmd.valid  = 1'b0;
        cmd.action = ACT_TICK;
        cmd.value  = '0;
        rsp.ready  = 1'b0;

        send_idle_pct = 38;
        recv_idle_pct = 59;
        words_sent    = 0;
        settings_used = 0;
        home_now      = HOME_RESET;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values, then commands at the slow default step rate.
        read_registers();
        send_word(ACT_TELL, '0);
        send_word(ACTION_BITS'(ACT_ZERO + 7), '1);
        send_word(ACT_GOTO, 24'sd3);
        send_word(ACT_TICK, '0);
        send_word(ACT_HOME, '0);
        send_word(ACT_RELEASE, '0);
        send_word(ACT_HOLD, '0);
        send_word(ACT_HOLD, 24'sd1);
        send_word(ACT_ZERO, '0);

        // Fastest nonzero rate, home at the top of the range: finish saturates there,
        // then a short move down ends with a stop that carries the pending report.
        wait_for_results();
        set_registers($urandom(), 24'd1, VALUE_BITS'(VALUE_MAX));
        send_word(ACT_ZERO, '0);
        send_word(ACT_FINISH, '0);
        send_word(ACT_RUN, 24'sd1);
        send_word(ACT_TICK, '0);
        send_word(ACT_GOTO, VALUE_BITS'(VALUE_MAX - 2));
        repeat (5) send_word(ACT_TICK, '0);
        send_word(ACT_TELL, '0);

        // Zero half period fires on every tick; home at the bottom of the range.
        wait_for_results();
        set_registers('0, '0, VALUE_BITS'(VALUE_MIN));
        send_word(ACT_ZERO, '0);
        send_word(ACT_RUN, VALUE_BITS'(VALUE_MIN));
        send_word(ACT_FINISH, '0);
        send_word(ACT_GOTO, VALUE_BITS'(VALUE_MIN + 1));
        repeat (3) send_word(ACT_TICK, '0);

        // Random settings for the random words.
        codes[0] = $urandom();  periods[0] = 24'd1;  homes[0] = '0;
        codes[1] = '1;          periods[1] = 24'd3;  homes[1] = VALUE_BITS'(VALUE_MAX);
        codes[2] = $urandom();  periods[2] = 24'd2;  homes[2] = VALUE_BITS'(VALUE_MIN);
        codes[3] = $urandom();  periods[3] = '1;     homes[3] = VALUE_BITS'($urandom());
        codes[4] = $urandom();  periods[4] = 24'd4;
        homes[4] = VALUE_BITS'(int'($urandom_range(100)) - 50);
        codes[5] = $urandom();  periods[5] = 24'd1;  homes[5] = -24'sd7;

        for (ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 38;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_for_results();
            set_registers(codes[ph], periods[ph], homes[ph]);
            for (n = 0; n < WORDS_PER_SETTING; n++)
            begin
                send_random_word();
            end
        end

        wait_for_results();
        repeat (10) @(posedge clk);

        failures = mismatches;
        if (words_waiting != 0)
        begin
            $display("tb: %0d expected result words never arrived", words_waiting);
            failures += words_waiting;
        end
        $display("tb: %0d command words over %0d register settings, %0d result words compared",
                 words_sent, settings_used, words_checked);
        $display("tb: %0d stops at the goal and %0d position reports among them",
                 stops_seen, reports_seen);
        if (failures == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: stepper_half_step_position_controller.f
hdl/shpc_pkg.sv
hdl/shpc_if.sv
hdl/shpc_cfg_regs.sv
hdl/stepper_half_step_position_controller.sv
sim/shpc_motion_checker.sv
sim/tb.sv
